// ----- rtl/core/pngw_pkg.sv -----
// ----------------------------------------------------------------------------
// pngw_pkg: shared types, constants and helpers of the PNG stored writer
// Phase codes of the byte sequencer, CRC-32 step, chunk type words.
// ----------------------------------------------------------------------------
`default_nettype none

package pngw_pkg;

  localparam int DIM_W         = 15;     // width of a dimension register
  localparam int RAW_W         = 31;     // zlib payload byte count
  localparam int LEN_W         = 32;     // chunk length field
  localparam int BLK_W         = 16;     // stored block length
  localparam int RBI_W         = 17;     // byte position within a row
  localparam int IDX_W         = 4;      // byte index within a phase
  localparam int CNT_W         = 6;      // results of one transaction
  localparam int RES_LIMIT     = 51;
  localparam int DEF_MAX_DIM   = 16384;
  localparam int DEF_BLOCK_MAX = 65535;

  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454e44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [7:0]  BIT_DEPTH = 8'd8;
  localparam logic [7:0]  COLOR_RGBA = 8'd6;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_SIG,
    PH_IHDR_LEN,
    PH_IHDR_TYPE,
    PH_IHDR_DATA,
    PH_IHDR_CRC,
    PH_IDAT_LEN,
    PH_IDAT_TYPE,
    PH_ZHDR,
    PH_BHDR,
    PH_FILT,
    PH_DATA,
    PH_ADLER,
    PH_DCRC,
    PH_IEND_LEN,
    PH_IEND_TYPE,
    PH_IEND_CRC
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       file_end;
  } beat_t;

  typedef struct packed {
    logic busy;
    logic item_done;
    logic at_idat_len;
    logic started;      // an image is open
  } gen_status_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte of a word, sel 0 is the top byte
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] sel);
    logic [7:0] r;
    case (sel)
      3'd0:    r = 8'd137;
      3'd1:    r = 8'd80;
      3'd2:    r = 8'd78;
      3'd3:    r = 8'd71;
      3'd4:    r = 8'd13;
      3'd5:    r = 8'd10;
      3'd6:    r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

  // index of the last byte of each phase
  function automatic logic [IDX_W-1:0] phase_last_idx(input phase_t ph);
    logic [IDX_W-1:0] r;
    case (ph)
      PH_SIG:       r = IDX_W'(7);
      PH_IHDR_DATA: r = IDX_W'(12);
      PH_ZHDR:      r = IDX_W'(1);
      PH_BHDR:      r = IDX_W'(4);
      PH_FILT,
      PH_DATA,
      PH_IDLE:      r = IDX_W'(0);
      default:      r = IDX_W'(3);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/png_rgba8_stored_writer.sv -----
// ----------------------------------------------------------------------------
// png_rgba8_stored_writer: streaming uncompressed PNG writer, RGBA8
// RGBA channel bytes in raster order in, complete PNG file bytes out
// (signature, IHDR, one IDAT of stored deflate blocks, IEND).
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  input   | in        | in_valid / in_stall   | pixel_byte
//  output  | out       | out_valid / out_stall | out_byte, run_last, file_end
//  config  | in        | cfg_write             | cfg_addr, cfg_data
//
// One output byte per cycle when the sink does not stall. A transaction in
// the middle of the image gives 1 byte, 2 at a row start, 5 more where a
// stored block begins; the first of an image gives 43 header bytes on
// top, the last 20 more for the trailer. The byte sequencer sets this rate.
// Reset (rst, synchronous) clears the sequencer and sets both dimensions to 1.
// in_stall follows out_stall through the output register in the same cycle;
// the block count is registered by the divider after the first signature
// byte, long before the IDAT length goes out.
`default_nettype none

module png_rgba8_stored_writer #(
  parameter int MAX_DIM   = pngw_pkg::DEF_MAX_DIM,
  parameter int BLOCK_MAX = pngw_pkg::DEF_BLOCK_MAX
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 pixel_byte,
  // output channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            run_last,
  output logic                            file_end,
  // configuration
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_addr,
  input  wire logic [pngw_pkg::DIM_W-1:0] cfg_data
);

  localparam int DW = pngw_pkg::DIM_W;
  localparam int RW = pngw_pkg::RAW_W;

  logic [DW-1:0] image_width, image_height;
  logic [DW-1:0] w_eff, h_eff;
  logic [pngw_pkg::RBI_W-1:0] row_len;
  logic [RW-1:0] raw_total, blocks;
  logic [31:0]   raw_prod;
  logic          accept, out_ready, div_start, div_busy, beat_emit;
  pngw_pkg::beat_t       beat;
  pngw_pkg::gen_status_t st;

  // configuration registers; writes are dropped while an image is open
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DW'(1);
      image_height <= DW'(1);
    end else if (cfg_write && !st.started && !st.busy) begin
      case (cfg_addr)
        pngw_pkg::CFG_WIDTH:  image_width  <= cfg_data;
        default:              image_height <= cfg_data;
      endcase
    end
  end

  // zero reads as one, anything past MAX_DIM as MAX_DIM
  assign w_eff = (image_width == '0) ? DW'(1)
               : (image_width > DW'(MAX_DIM)) ? DW'(MAX_DIM) : image_width;
  assign h_eff = (image_height == '0) ? DW'(1)
               : (image_height > DW'(MAX_DIM)) ? DW'(MAX_DIM) : image_height;
  assign row_len  = {w_eff, 2'b00};

  // payload size incl. filter bytes, registered behind the multiplier
  assign raw_prod = {15'd0, row_len + 1'b1} * {17'd0, h_eff};

  always_ff @(posedge clk) begin
    raw_total <= raw_prod[RW-1:0];
  end

  pngw_div #(
    .DIVISOR (BLOCK_MAX)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (raw_total),
    .quot  (blocks),
    .busy  (div_busy)
  );

  // the output register frees up when empty or when its byte is taken
  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = st.busy && !st.item_done;
  assign accept    = in_valid && !in_stall;

  pngw_gen #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pix_in    (pixel_byte),
    .out_ready (out_ready),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .row_len   (row_len),
    .raw_total (raw_total),
    .blocks    (blocks),
    .div_start (div_start),
    .beat      (beat),
    .beat_emit (beat_emit),
    .status    (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_emit) begin
      out_byte <= beat.data;
      run_last <= beat.run_last;
      file_end <= beat.file_end;
    end
  end

  // block count must be ready before the IDAT length goes out
  a_div_ready: assert property (@(posedge clk) disable iff (rst)
    st.at_idat_len |-> !div_busy)
    else $error("IDAT length reached with divider busy");

  // never overwrite a held byte
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (beat_emit && out_valid) |-> !out_stall)
    else $error("output register overrun");

  // file end closes a transaction
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && file_end) |-> run_last)
    else $error("file_end without run_last");

  // a transaction in progress blocks the next one
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (st.busy && !st.item_done) |-> in_stall)
    else $error("input taken while sequencer busy");

endmodule

`default_nettype wire

// ----- rtl/core/pngw_div.sv -----
// ----------------------------------------------------------------------------
// pngw_div: stored block count
// ceil(numer / DIVISOR) by reciprocal multiplication; the rounded-up
// numerator is registered at start, then the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module pngw_div #(
  parameter int DIVISOR = pngw_pkg::DEF_BLOCK_MAX
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pngw_pkg::RAW_W-1:0] numer,
  output logic      [pngw_pkg::RAW_W-1:0] quot,
  output logic                            busy
);

  localparam int RW = pngw_pkg::RAW_W;
  localparam int LG = $clog2(DIVISOR);
  localparam int SH = RW + LG;
  // ceil(2^SH / DIVISOR) stays below 2^32 and is exact for any RW-bit numerator
  localparam logic [63:0] RECIP   = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [31:0] RECIP_W = RECIP[31:0];

  logic [RW-1:0]    num_q;    // rounded-up numerator
  logic [RW+31:0]   prod;

  assign prod = {32'd0, num_q} * {31'd0, RECIP_W};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= numer + RW'(DIVISOR - 1);
    end
    if (busy) begin
      quot <= RW'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pngw_gen.sv -----
// ----------------------------------------------------------------------------
// pngw_gen: PNG byte sequencer
// Walks the phases of one transaction, one file byte per cycle while the
// output register is free, and keeps CRC-32, Adler-32, block and row counters.
// ----------------------------------------------------------------------------
`default_nettype none

module pngw_gen #(
  parameter int BLOCK_MAX = pngw_pkg::DEF_BLOCK_MAX
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [7:0]                 pix_in,
  input  wire logic                       out_ready,
  input  wire logic [pngw_pkg::DIM_W-1:0] w_eff,
  input  wire logic [pngw_pkg::DIM_W-1:0] h_eff,
  input  wire logic [pngw_pkg::RBI_W-1:0] row_len,
  input  wire logic [pngw_pkg::RAW_W-1:0] raw_total,
  input  wire logic [pngw_pkg::RAW_W-1:0] blocks,
  output logic                            div_start,
  output pngw_pkg::beat_t                 beat,
  output logic                            beat_emit,
  output pngw_pkg::gen_status_t           status
);

  localparam int RW = pngw_pkg::RAW_W;
  localparam int BW = pngw_pkg::BLK_W;
  localparam int IW = pngw_pkg::IDX_W;
  localparam int CW = pngw_pkg::CNT_W;

  pngw_pkg::phase_t phase, phase_next, raw_ph, entry_ph;
  logic             ret, ret_next, raw_ret;   // after a block header: 1 filter, 0 data
  logic [IW-1:0]    idx, idx_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [7:0]       pix;

  logic             started, started_next;
  logic [RW-1:0]    raw_left, raw_left_next;
  logic [BW-1:0]    block_left, block_left_next;
  logic [pngw_pkg::RBI_W-1:0] rbi, rbi_next;
  logic [31:0]      crc, crc_next, crc_src;
  logic [15:0]      adler_low, adler_low_next, adler_high, adler_high_next;

  logic             busy, limited, adv, last_in_phase, seq_end, crc_upd;
  logic [7:0]       data;
  logic [BW-1:0]    blen;
  logic             bfinal;
  logic [31:0]      idat_len;
  logic [16:0]      a_sum, h_sum;
  logic [15:0]      a_low, a_high;
  logic [pngw_pkg::RBI_W-1:0] rbi_inc;

  assign busy          = phase != pngw_pkg::PH_IDLE;
  assign limited       = cnt == CW'(pngw_pkg::RES_LIMIT);
  assign adv           = busy && (limited || out_ready);
  assign last_in_phase = idx == pngw_pkg::phase_last_idx(phase);
  assign seq_end       = last_in_phase && ((phase == pngw_pkg::PH_DATA && raw_left != RW'(1))
                                           || phase == pngw_pkg::PH_IEND_CRC);

  assign blen     = (raw_left < RW'(BLOCK_MAX)) ? raw_left[BW-1:0] : BW'(BLOCK_MAX);
  assign bfinal   = raw_left <= RW'(BLOCK_MAX);
  assign idat_len = {1'b0, raw_total} + {blocks[RW-2:0], 2'b00} + {1'b0, blocks} + 32'd6;

  // Adler-32 step; filter bytes carry zero
  assign a_sum  = {1'b0, adler_low} + {9'd0, (phase == pngw_pkg::PH_DATA) ? pix : 8'd0};
  assign a_low  = (a_sum >= pngw_pkg::ADLER_MOD) ? 16'(a_sum - pngw_pkg::ADLER_MOD)
                                                 : a_sum[15:0];
  assign h_sum  = {1'b0, adler_high} + {1'b0, a_low};
  assign a_high = (h_sum >= pngw_pkg::ADLER_MOD) ? 16'(h_sum - pngw_pkg::ADLER_MOD)
                                                 : h_sum[15:0];
  assign rbi_inc = rbi + 1'b1;

  // byte select and output flags
  always_comb begin
    data    = 8'd0;
    crc_upd = 1'b0;
    crc_src = crc;
    unique case (phase)
      pngw_pkg::PH_SIG:       data = pngw_pkg::sig_byte(idx[2:0]);
      pngw_pkg::PH_IHDR_LEN:  data = pngw_pkg::be_byte(pngw_pkg::IHDR_LEN, idx[1:0]);
      pngw_pkg::PH_IHDR_TYPE: begin
        data    = pngw_pkg::be_byte(pngw_pkg::TYPE_IHDR, idx[1:0]);
        crc_upd = 1'b1;
        if (idx == '0) crc_src = pngw_pkg::CRC_INIT;
      end
      pngw_pkg::PH_IHDR_DATA: begin
        crc_upd = 1'b1;
        if (idx < IW'(4)) begin
          data = pngw_pkg::be_byte({17'd0, w_eff}, idx[1:0]);
        end else if (idx < IW'(8)) begin
          data = pngw_pkg::be_byte({17'd0, h_eff}, idx[1:0]);
        end else if (idx == IW'(8)) begin
          data = pngw_pkg::BIT_DEPTH;
        end else if (idx == IW'(9)) begin
          data = pngw_pkg::COLOR_RGBA;
        end
      end
      pngw_pkg::PH_IHDR_CRC,
      pngw_pkg::PH_DCRC,
      pngw_pkg::PH_IEND_CRC:  data = pngw_pkg::be_byte(~crc, idx[1:0]);
      pngw_pkg::PH_IDAT_LEN:  data = pngw_pkg::be_byte(idat_len, idx[1:0]);
      pngw_pkg::PH_IDAT_TYPE: begin
        data    = pngw_pkg::be_byte(pngw_pkg::TYPE_IDAT, idx[1:0]);
        crc_upd = 1'b1;
        if (idx == '0) crc_src = pngw_pkg::CRC_INIT;
      end
      pngw_pkg::PH_ZHDR: begin
        data    = (idx == '0) ? pngw_pkg::ZLIB_CMF : pngw_pkg::ZLIB_FLG;
        crc_upd = 1'b1;
      end
      pngw_pkg::PH_BHDR: begin
        crc_upd = 1'b1;
        case (idx[2:0])
          3'd0:    data = {7'd0, bfinal};
          3'd1:    data = blen[7:0];
          3'd2:    data = blen[15:8];
          3'd3:    data = ~blen[7:0];
          default: data = ~blen[15:8];
        endcase
      end
      pngw_pkg::PH_FILT:      crc_upd = 1'b1;
      pngw_pkg::PH_DATA: begin
        data    = pix;
        crc_upd = 1'b1;
      end
      pngw_pkg::PH_ADLER: begin
        data    = pngw_pkg::be_byte({adler_high, adler_low}, idx[1:0]);
        crc_upd = 1'b1;
      end
      pngw_pkg::PH_IEND_LEN:  data = 8'd0;
      pngw_pkg::PH_IEND_TYPE: begin
        data    = pngw_pkg::be_byte(pngw_pkg::TYPE_IEND, idx[1:0]);
        crc_upd = 1'b1;
        if (idx == '0) crc_src = pngw_pkg::CRC_INIT;
      end
      default: data = 8'd0;
    endcase
  end

  assign beat.data     = data;
  assign beat.run_last = seq_end || (cnt == CW'(pngw_pkg::RES_LIMIT - 1));
  assign beat.file_end = seq_end && phase == pngw_pkg::PH_IEND_CRC;
  assign beat_emit     = adv && !limited;
  assign div_start     = adv && phase == pngw_pkg::PH_SIG && idx == '0;

  assign status.busy        = busy;
  assign status.item_done   = adv && seq_end;
  assign status.at_idat_len = phase == pngw_pkg::PH_IDAT_LEN;
  assign status.started     = started;

  // stream state
  always_comb begin
    started_next    = started;
    raw_left_next   = raw_left;
    block_left_next = block_left;
    rbi_next        = rbi;
    crc_next        = crc;
    adler_low_next  = adler_low;
    adler_high_next = adler_high;
    cnt_next        = cnt;
    if (adv) begin
      if (!limited) cnt_next = cnt + 1'b1;
      if (crc_upd) crc_next = pngw_pkg::crc_byte(crc_src, data);
      unique case (phase)
        pngw_pkg::PH_SIG: begin
          if (idx == '0) begin
            started_next    = 1'b1;
            block_left_next = '0;
            rbi_next        = '0;
            adler_low_next  = 16'd1;
            adler_high_next = 16'd0;
          end
        end
        pngw_pkg::PH_ZHDR: begin
          if (last_in_phase) raw_left_next = raw_total;
        end
        pngw_pkg::PH_BHDR: begin
          if (last_in_phase) block_left_next = blen;
        end
        pngw_pkg::PH_FILT,
        pngw_pkg::PH_DATA: begin
          block_left_next = block_left - 1'b1;
          raw_left_next   = raw_left - 1'b1;
          adler_low_next  = a_low;
          adler_high_next = a_high;
          if (phase == pngw_pkg::PH_DATA) begin
            rbi_next = (rbi_inc >= row_len) ? '0 : rbi_inc;
          end
        end
        pngw_pkg::PH_IEND_CRC: begin
          if (last_in_phase) begin
            started_next    = 1'b0;
            block_left_next = '0;
            rbi_next        = '0;
            crc_next        = pngw_pkg::CRC_INIT;
            adler_low_next  = 16'd1;
            adler_high_next = 16'd0;
          end
        end
        default: ;
      endcase
    end
    if (accept) cnt_next = '0;
  end

  // where the raw path of a transaction starts, seen from the next state
  always_comb begin
    raw_ret = rbi_next == '0;
    if (block_left_next == '0) begin
      raw_ph = pngw_pkg::PH_BHDR;
    end else if (rbi_next == '0) begin
      raw_ph = pngw_pkg::PH_FILT;
    end else begin
      raw_ph = pngw_pkg::PH_DATA;
    end
    entry_ph = started_next ? raw_ph : pngw_pkg::PH_SIG;
  end

  // phase sequencing
  always_comb begin
    phase_next = phase;
    ret_next   = ret;
    idx_next   = idx;
    if (adv) begin
      idx_next = idx + 1'b1;
      if (last_in_phase) begin
        idx_next = '0;
        unique case (phase)
          pngw_pkg::PH_SIG:       phase_next = pngw_pkg::PH_IHDR_LEN;
          pngw_pkg::PH_IHDR_LEN:  phase_next = pngw_pkg::PH_IHDR_TYPE;
          pngw_pkg::PH_IHDR_TYPE: phase_next = pngw_pkg::PH_IHDR_DATA;
          pngw_pkg::PH_IHDR_DATA: phase_next = pngw_pkg::PH_IHDR_CRC;
          pngw_pkg::PH_IHDR_CRC:  phase_next = pngw_pkg::PH_IDAT_LEN;
          pngw_pkg::PH_IDAT_LEN:  phase_next = pngw_pkg::PH_IDAT_TYPE;
          pngw_pkg::PH_IDAT_TYPE: phase_next = pngw_pkg::PH_ZHDR;
          pngw_pkg::PH_ZHDR: begin
            phase_next = raw_ph;
            ret_next   = raw_ret;
          end
          pngw_pkg::PH_BHDR:      phase_next = ret ? pngw_pkg::PH_FILT : pngw_pkg::PH_DATA;
          pngw_pkg::PH_FILT: begin
            phase_next = (block_left_next == '0) ? pngw_pkg::PH_BHDR : pngw_pkg::PH_DATA;
            ret_next   = 1'b0;
          end
          pngw_pkg::PH_DATA:      phase_next = pngw_pkg::PH_ADLER;
          pngw_pkg::PH_ADLER:     phase_next = pngw_pkg::PH_DCRC;
          pngw_pkg::PH_DCRC:      phase_next = pngw_pkg::PH_IEND_LEN;
          pngw_pkg::PH_IEND_LEN:  phase_next = pngw_pkg::PH_IEND_TYPE;
          pngw_pkg::PH_IEND_TYPE: phase_next = pngw_pkg::PH_IEND_CRC;
          default:                phase_next = pngw_pkg::PH_IDLE;
        endcase
      end
      if (seq_end) phase_next = pngw_pkg::PH_IDLE;
    end
    if (accept) begin
      phase_next = entry_ph;
      ret_next   = raw_ret;
      idx_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pngw_pkg::PH_IDLE;
      ret        <= 1'b0;
      idx        <= '0;
      cnt        <= '0;
      started    <= 1'b0;
      raw_left   <= '0;
      block_left <= '0;
      rbi        <= '0;
      crc        <= pngw_pkg::CRC_INIT;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else begin
      phase      <= phase_next;
      ret        <= ret_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      started    <= started_next;
      raw_left   <= raw_left_next;
      block_left <= block_left_next;
      rbi        <= rbi_next;
      crc        <= crc_next;
      adler_low  <= adler_low_next;
      adler_high <= adler_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pix <= pix_in;
  end

endmodule

`default_nettype wire

// ----- tb/sv/png_rgba8_stored_writer_tb.sv -----
// ----------------------------------------------------------------------------
// png_rgba8_stored_writer_tb: self-checking bench for the PNG stored writer
// Streams small RGBA8 images through the writer, builds the expected PNG
// byte stream on the side (headers, stored blocks, Adler-32, CRC-32) and
// compares every output byte in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module png_rgba8_stored_writer_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       file_end;
  } png_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] pixel_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic run_last;
  logic file_end;
  logic cfg_write = 1'b0;
  logic cfg_addr = pngw_pkg::CFG_WIDTH;
  logic [pngw_pkg::DIM_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  png_rgba8_stored_writer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_byte(pixel_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .file_end(file_end),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow of the writer's state
  logic [pngw_pkg::DIM_W-1:0] sh_width, sh_height;
  logic [31:0] sh_crc;
  logic [31:0] sh_adler_lo, sh_adler_hi;
  int unsigned sh_row_pos, sh_blk_left, sh_raw_left;
  bit sh_active;
  png_beat_t step_beats[$];

  png_beat_t expected_bytes[$];
  logic [7:0] pixel_queue[$];
  int errors = 0;

  logic [7:0] sig_bytes_c[8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};

  function automatic int unsigned clamp_dim(input logic [pngw_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 16384) return 16384;
    return {17'd0, v};
  endfunction

  function automatic void emit(input logic [7:0] b, input bit with_crc);
    png_beat_t e;
    if (with_crc) begin
      sh_crc = sh_crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
        sh_crc = sh_crc[0] ? (32'hedb88320 ^ (sh_crc >> 1)) : (sh_crc >> 1);
    end
    e.data = b; e.run_last = 0; e.file_end = 0;
    if (step_beats.size() < 51) step_beats = {step_beats, e};
  endfunction

  function automatic void emit_word(input logic [31:0] v, input bit with_crc);
    for (int s = 24; s >= 0; s -= 8) emit(8'(v >> s), with_crc);
  endfunction

  function automatic void emit_type(input logic [31:0] t);
    sh_crc = 32'hffffffff;
    emit_word(t, 1'b1);
  endfunction

  function automatic void emit_payload(input logic [7:0] b);
    int unsigned len;
    if (sh_raw_left == 0) return;
    if (sh_blk_left == 0) begin
      len = sh_raw_left < 65535 ? sh_raw_left : 65535;
      emit({7'd0, len == sh_raw_left}, 1'b1);
      emit(len[7:0], 1'b1);
      emit(len[15:8], 1'b1);
      emit(~len[7:0], 1'b1);
      emit(~len[15:8], 1'b1);
      sh_blk_left = len;
    end
    emit(b, 1'b1);
    sh_adler_lo = (sh_adler_lo + b) % 65521;
    sh_adler_hi = (sh_adler_hi + sh_adler_lo) % 65521;
    sh_blk_left--;
    sh_raw_left--;
  endfunction

  // Expected file bytes caused by one accepted pixel byte
  function automatic void predict_png_bytes(input logic [7:0] pb);
    int unsigned w, h, raw, blocks;
    int end_idx;
    end_idx = -1;
    step_beats.delete();
    w = clamp_dim(sh_width);
    h = clamp_dim(sh_height);
    if (!sh_active) begin
      raw = (w * 4 + 1) * h;
      blocks = (raw + 65534) / 65535;
      foreach (sig_bytes_c[i]) emit(sig_bytes_c[i], 1'b0);
      emit_word(32'd13, 1'b0);
      emit_type(pngw_pkg::TYPE_IHDR);
      emit_word(w, 1'b1);
      emit_word(h, 1'b1);
      emit(8'd8, 1'b1); emit(8'd6, 1'b1); emit(8'd0, 1'b1);
      emit(8'd0, 1'b1); emit(8'd0, 1'b1);
      emit_word(~sh_crc, 1'b0);
      emit_word(raw + 5 * blocks + 6, 1'b0);
      emit_type(pngw_pkg::TYPE_IDAT);
      emit(pngw_pkg::ZLIB_CMF, 1'b1);
      emit(pngw_pkg::ZLIB_FLG, 1'b1);
      sh_raw_left = raw; sh_blk_left = 0; sh_row_pos = 0;
      sh_adler_lo = 1; sh_adler_hi = 0; sh_active = 1;
    end
    if (sh_row_pos == 0) emit_payload(8'd0);   // filter type none
    emit_payload(pb);
    sh_row_pos++;
    if (sh_row_pos >= w * 4) sh_row_pos = 0;
    if (sh_raw_left == 0) begin
      emit_word({sh_adler_hi[15:0], sh_adler_lo[15:0]}, 1'b1);
      emit_word(~sh_crc, 1'b0);
      emit_word(32'd0, 1'b0);
      emit_type(pngw_pkg::TYPE_IEND);
      emit_word(~sh_crc, 1'b0);
      end_idx = step_beats.size() - 1;
      sh_active = 0; sh_row_pos = 0; sh_blk_left = 0;
      sh_crc = 32'hffffffff; sh_adler_lo = 1; sh_adler_hi = 0;
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1;
    if (end_idx >= 0) step_beats[end_idx].file_end = 1;
    foreach (step_beats[i]) expected_bytes = {expected_bytes, step_beats[i]};
  endfunction

  // Driver: one pixel byte per transaction, random gap before each
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_png_bytes(pixel_byte);
        void'(pixel_queue.pop_front());
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_valid <= 1'b1;
        pixel_byte <= pixel_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every output byte against the oldest expectation
  int out_hold = 0;
  always @(posedge clk) begin
    png_beat_t exp_b;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output: byte %h run_last %b file_end %b",
                   $time, out_byte, run_last, file_end);
          errors++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, exp_b.data, out_byte);
            errors++;
          end
          if (run_last !== exp_b.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, exp_b.run_last, run_last);
            errors++;
          end
          if (file_end !== exp_b.file_end) begin
            $display("%0t: file_end expected %b actual %b", $time, exp_b.file_end, file_end);
            errors++;
          end
        end
        out_hold = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [pngw_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    // writes land only while the writer is idle
    if (!sh_active) begin
      if (idx == pngw_pkg::CFG_WIDTH) sh_width = val;
      else sh_height = val;
    end
  endtask

  // Queue pixel bytes, then wait until the stream drained
  task automatic send_image(input int unsigned nbytes, input bit extremes);
    for (int i = 0; i < nbytes; i++) begin
      if (extremes) pixel_queue = {pixel_queue, (i[0] ? 8'hff : 8'h00)};
      else pixel_queue = {pixel_queue, 8'($urandom_range(0, 255))};
    end
    while (pixel_queue.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h;
    sh_width = 1; sh_height = 1; sh_crc = 32'hffffffff;
    sh_adler_lo = 1; sh_adler_hi = 0; sh_row_pos = 0; sh_blk_left = 0;
    sh_raw_left = 0; sh_active = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Directed: reset size 1x1, extreme byte values
    send_image(4, 1'b1);
    // Zero dimensions read as one
    write_reg(pngw_pkg::CFG_WIDTH, 15'd0);
    write_reg(pngw_pkg::CFG_HEIGHT, 15'd0);
    send_image(4, 1'b0);
    // A write while an image is open must be dropped
    write_reg(pngw_pkg::CFG_WIDTH, 15'd2);
    write_reg(pngw_pkg::CFG_HEIGHT, 15'd2);
    send_image(2, 1'b0);
    write_reg(pngw_pkg::CFG_WIDTH, 15'd1);
    send_image(14, 1'b0);
    // Random phase: small images
    for (int n = 0; n < 7; n++) begin
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      write_reg(pngw_pkg::CFG_WIDTH, pngw_pkg::DIM_W'(w));
      write_reg(pngw_pkg::CFG_HEIGHT, pngw_pkg::DIM_W'(h));
      send_image(w * h * 4, 1'b0);
    end
    // Largest register values clamp to the max dimension; the image is
    // only started, which covers the headers and the block count
    write_reg(pngw_pkg::CFG_WIDTH, 15'h7fff);
    write_reg(pngw_pkg::CFG_HEIGHT, 15'h7fff);
    send_image(6, 1'b0);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
